@@ sv/cqsi_pkg.sv @@
// shared types, constants and helpers for the segment interpolator
`default_nettype none
package cqsi_pkg;

  localparam int MAX_SAMPLES_DEF = 64;
  localparam int CFG_SAMPLES_W   = 7;
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 8;
  localparam int POS_W           = 32;
  localparam int DUR_W           = 32;
  localparam int TIME_W          = 48;
  localparam int TAU_W           = 17;
  localparam int PW_W            = 25;
  localparam int MUL_W           = 34;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int NUM_W           = 68;
  localparam int DEN_W           = 64;
  localparam int QUO_W           = 33;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SAMPLES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_KIND    = 8'd1;
  localparam logic                 KIND_CUBIC      = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DSQ, ST_FIRST, ST_TDIV, ST_TWAIT, ST_TT, ST_P3, ST_P4, ST_P5,
    ST_POLY, ST_SD, ST_POS, ST_TD, ST_TIME, ST_VD, ST_VDIV, ST_VWAIT, ST_AD,
    ST_ADIV, ST_AWAIT, ST_EMIT, ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_TT, MUL_P3, MUL_P4, MUL_P5, MUL_SD, MUL_VD, MUL_AD, MUL_DD, MUL_TD
  } mul_op_t;

  typedef enum logic [1:0] {
    DIV_T, DIV_V, DIV_A
  } div_sel_t;

  typedef struct packed {
    logic     load_seg;
    mul_op_t  mul_op;
    logic     poly;
    logic     pos_ld;
    logic     time_ld;
    logic     t_zero;
    logic     rates_zero;
    logic     div_start;
    div_sel_t div_sel;
    logic     k_inc;
    logic     emit;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_first;
    logic n_one;
    logic k_last;
    logic dur_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

  // saturate a signed magnitude to a 32-bit two's complement value
  function automatic logic signed [POS_W-1:0] sat_mag(input logic neg, input logic ovf,
                                                      input logic [QUO_W-1:0] q);
    logic signed [POS_W-1:0] r;
    if (neg) begin
      if (ovf || (q > 33'h080000000)) r = 32'sh80000000;
      else r = $signed((~q[POS_W-1:0]) + 32'd1);
    end else begin
      if (ovf || (q > 33'h07FFFFFFF)) r = 32'sh7FFFFFFF;
      else r = $signed(q[POS_W-1:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/cubic_quintic_segment_interpolator_unit.sv @@
// top level of the one-axis cubic/quintic smoothstep segment interpolator
// per sample: up to three passes through the 33-step serial divider (for tau, velocity,
//   acceleration) plus the shared multiplier steps; tau is set to zero without a
//   division when the samples register gives one sample, and velocity and
//   acceleration are set to zero without divisions at zero duration
// segment requests are taken only in the idle state, after the previous segment has
//   finished, so the next request waits longer while the sample output is held off
// reset: rst (synchronous) clears time offset, trajectory flag and output valid;
//   samples register goes to 64, kind to quintic
`default_nettype none
module cubic_quintic_segment_interpolator_unit #(
  parameter int MAX_SAMPLES = cqsi_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // segment requests
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // start_position[31:0], end_position[63:32], segment_duration[95:64]
  input  wire logic [95:0]                         s_axis_tdata,
  // new_trajectory
  input  wire logic                                s_axis_tuser,
  // samples
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // sample_time[47:0], position[79:48], velocity[111:80], acceleration[143:112]
  output logic [143:0]                             m_axis_tdata,
  // last_sample
  output logic                                     m_axis_tlast,
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cqsi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cqsi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cqsi_pkg::*;

  // configuration registers
  logic [CFG_SAMPLES_W-1:0] cfg_samples;
  logic                     cfg_kind;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_samples <= CFG_SAMPLES_W'(64);
      cfg_kind    <= 1'b1;
    end else if (cfg_valid) begin
      // writes to unknown indexes fall through
      if (cfg_index == CFG_IDX_SAMPLES) cfg_samples <= cfg_data[CFG_SAMPLES_W-1:0];
      else if (cfg_index == CFG_IDX_KIND) cfg_kind <= cfg_data[0];
    end
  end

  dp_cmd_t    cmd;
  dp_status_t st;

  // controller: one segment at a time, one sample step at a time
  cqsi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .st       (st)
  );

  logic [TIME_W-1:0]       o_time;
  logic signed [POS_W-1:0] o_pos, o_vel, o_acc;

  // datapath: multiplier, divider and the sample output register
  cqsi_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_samples (cfg_samples),
    .cfg_kind    (cfg_kind),
    .in_start    ($signed(s_axis_tdata[31:0])),
    .in_end      ($signed(s_axis_tdata[63:32])),
    .in_dur      (s_axis_tdata[95:64]),
    .in_fresh    (s_axis_tuser),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_time    (o_time),
    .out_pos     (o_pos),
    .out_vel     (o_vel),
    .out_acc     (o_acc),
    .out_last    (m_axis_tlast)
  );

  // pack sample fields, lowest field first
  assign m_axis_tdata = {o_acc, o_vel, o_pos, o_time};

endmodule
`default_nettype wire

@@ sv/cqsi_div.sv @@
// serial restoring divider, one quotient bit per cycle with overflow flag
`default_nettype none
module cqsi_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [cqsi_pkg::NUM_W-1:0] num,
  input  wire logic [cqsi_pkg::DEN_W-1:0] den,
  output logic                            done,
  output logic [cqsi_pkg::QUO_W-1:0]      quot,
  output logic                            ovf
);
  import cqsi_pkg::*;

  localparam int SH_W  = DEN_W + QUO_W - 1;
  localparam int CNT_W = $clog2(QUO_W);

  logic [NUM_W-1:0] rem;
  logic [SH_W-1:0]  dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             ge;

  assign ge = {{(SH_W-NUM_W){1'b0}}, rem} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= {den, {(QUO_W-1){1'b0}}};
      quot <= '0;
      ovf  <= {{(SH_W+1-NUM_W){1'b0}}, num} >= {den, {QUO_W{1'b0}}};
    end else if (busy) begin
      if (ge) rem <= rem - dsh[NUM_W-1:0];
      quot <= {quot[QUO_W-2:0], ge};
      dsh  <= dsh >> 1;
    end
  end

endmodule
`default_nettype wire

@@ sv/cqsi_datapath.sv @@
// interpolator datapath: segment registers, shared multiplier, divider, output register
`default_nettype none
module cqsi_datapath #(
  parameter int MAX_SAMPLES = cqsi_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire cqsi_pkg::dp_cmd_t                  cmd,
  output cqsi_pkg::dp_status_t                    st,
  input  wire logic [cqsi_pkg::CFG_SAMPLES_W-1:0] cfg_samples,
  input  wire logic                               cfg_kind,
  input  wire logic signed [cqsi_pkg::POS_W-1:0]  in_start,
  input  wire logic signed [cqsi_pkg::POS_W-1:0]  in_end,
  input  wire logic [cqsi_pkg::DUR_W-1:0]         in_dur,
  input  wire logic                               in_fresh,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [cqsi_pkg::TIME_W-1:0]             out_time,
  output logic signed [cqsi_pkg::POS_W-1:0]       out_pos,
  output logic signed [cqsi_pkg::POS_W-1:0]       out_vel,
  output logic signed [cqsi_pkg::POS_W-1:0]       out_acc,
  output logic                                    out_last
);
  import cqsi_pkg::*;

  localparam int KW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam logic [CFG_SAMPLES_W-1:0] NMAX = CFG_SAMPLES_W'(MAX_SAMPLES);

  logic signed [POS_W-1:0]  start_r;
  logic signed [POS_W:0]    delta;
  logic [DUR_W-1:0]         dur;
  logic                     emit_first;
  logic                     started;
  logic [TIME_W-1:0]        offset;
  logic [KW-1:0]            k;
  logic [TAU_W-1:0]         tau;
  logic [PW_W-1:0]          p2, p3, p4, p5;
  logic signed [MUL_W-1:0]  s_r, ds_r, dds_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [DEN_W-1:0]         dur2;
  logic [TIME_W-1:0]        time_r;
  logic signed [POS_W-1:0]  pos_r, vel_r, acc_r;
  div_sel_t                 div_dst;

  // sample count after clamping
  logic [CFG_SAMPLES_W-1:0] n_cl;
  logic [KW-1:0]            nm1;
  always_comb begin
    if (cfg_samples == '0) n_cl = CFG_SAMPLES_W'(1);
    else if (cfg_samples > NMAX) n_cl = NMAX;
    else n_cl = cfg_samples;
  end
  assign nm1 = KW'(n_cl - CFG_SAMPLES_W'(1));

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      MUL_TT: begin mul_a = $signed(MUL_W'(tau)); mul_b = $signed(MUL_W'(tau)); end
      MUL_P3: begin mul_a = $signed(MUL_W'(p2)); mul_b = $signed(MUL_W'(tau)); end
      MUL_P4: begin mul_a = $signed(MUL_W'(p3)); mul_b = $signed(MUL_W'(tau)); end
      MUL_P5: begin mul_a = $signed(MUL_W'(p4)); mul_b = $signed(MUL_W'(tau)); end
      MUL_SD: begin mul_a = s_r;   mul_b = MUL_W'(delta); end
      MUL_VD: begin mul_a = ds_r;  mul_b = MUL_W'(delta); end
      MUL_AD: begin mul_a = dds_r; mul_b = MUL_W'(delta); end
      MUL_DD: begin mul_a = $signed(MUL_W'(dur)); mul_b = $signed(MUL_W'(dur)); end
      MUL_TD: begin mul_a = $signed(MUL_W'(tau)); mul_b = $signed(MUL_W'(dur)); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // magnitude of the stored product
  logic [PROD_W-1:0] mag;
  assign mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  // divider operands
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done, div_ovf;
  logic [QUO_W-1:0] div_quot;
  always_comb begin
    unique case (cmd.div_sel)
      DIV_T: begin
        div_num = (NUM_W'(k) << 17) + NUM_W'(nm1);
        div_den = DEN_W'(nm1) << 1;
      end
      DIV_V: begin
        div_num = mag;
        div_den = {{(DEN_W-DUR_W-8){1'b0}}, dur, 8'd0};
      end
      default: begin
        div_num = {mag[NUM_W-9:0], 8'd0};
        div_den = dur2;
      end
    endcase
  end

  cqsi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .ovf   (div_ovf)
  );

  // smoothstep polynomials
  logic signed [MUL_W-1:0] q1, q2, q3, q4, q5;
  logic signed [MUL_W-1:0] s_n, ds_n, dds_n;
  always_comb begin
    q1 = $signed(MUL_W'({tau, 8'd0}));
    q2 = $signed(MUL_W'(p2));
    q3 = $signed(MUL_W'(p3));
    q4 = $signed(MUL_W'(p4));
    q5 = $signed(MUL_W'(p5));
    if (cfg_kind == KIND_CUBIC) begin
      s_n   = 34'sd3 * q2 - 34'sd2 * q3;
      ds_n  = 34'sd6 * q1 - 34'sd6 * q2;
      dds_n = 34'sd100663296 - 34'sd12 * q1;
    end else begin
      s_n   = 34'sd10 * q3 - 34'sd15 * q4 + 34'sd6 * q5;
      ds_n  = 34'sd30 * q2 - 34'sd60 * q3 + 34'sd30 * q4;
      dds_n = 34'sd60 * q1 - 34'sd180 * q2 + 34'sd120 * q3;
    end
  end

  // position sum and saturation
  logic [43:0]         pm;
  logic signed [47:0]  psum;
  logic signed [POS_W-1:0] pos_n;
  always_comb begin
    pm   = mag[PROD_W-1:24];
    psum = 48'(start_r) + (prod_r[PROD_W-1] ? -$signed({4'd0, pm}) : $signed({4'd0, pm}));
    if (psum > 48'sd2147483647) pos_n = 32'sh7FFFFFFF;
    else if (psum < -48'sd2147483648) pos_n = 32'sh80000000;
    else pos_n = psum[POS_W-1:0];
  end

  // time sums
  logic [TIME_W:0] tsum, osum;
  assign tsum = {1'b0, offset} + (TIME_W+1)'(prod_r[48:16]);
  assign osum = {1'b0, offset} + (TIME_W+1)'(dur);

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      offset    <= '0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (cmd.load_seg) begin
        k <= '0;
        if (in_fresh) offset <= '0;
      end else if (cmd.k_inc) begin
        k <= k + 1'b1;
      end
      if (cmd.finish) begin
        started <= 1'b1;
        offset  <= osum[TIME_W] ? {TIME_W{1'b1}} : osum[TIME_W-1:0];
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seg) begin
      start_r    <= in_start;
      delta      <= (POS_W+1)'(in_end) - (POS_W+1)'(in_start);
      dur        <= in_dur;
      emit_first <= in_fresh || !started;
    end
    case (cmd.mul_op)
      MUL_TT: p2 <= prod[32:8];
      MUL_P3: p3 <= prod[40:16];
      MUL_P4: p4 <= prod[40:16];
      MUL_P5: p5 <= prod[40:16];
      MUL_SD, MUL_VD, MUL_AD, MUL_TD: prod_r <= prod;
      MUL_DD: dur2 <= prod[DEN_W-1:0];
      default: ;
    endcase
    if (cmd.poly) begin
      s_r   <= s_n;
      ds_r  <= ds_n;
      dds_r <= dds_n;
    end
    if (cmd.pos_ld) pos_r <= pos_n;
    if (cmd.time_ld) time_r <= tsum[TIME_W] ? {TIME_W{1'b1}} : tsum[TIME_W-1:0];
    if (cmd.t_zero) tau <= '0;
    if (cmd.rates_zero) begin
      vel_r <= '0;
      acc_r <= '0;
    end
    if (cmd.div_start) div_dst <= cmd.div_sel;
    if (div_done) begin
      unique case (div_dst)
        DIV_T:   tau   <= div_quot[TAU_W-1:0];
        DIV_V:   vel_r <= sat_mag(prod_r[PROD_W-1], div_ovf, div_quot);
        default: acc_r <= sat_mag(prod_r[PROD_W-1], div_ovf, div_quot);
      endcase
    end
    if (cmd.emit) begin
      out_time <= time_r;
      out_pos  <= pos_r;
      out_vel  <= vel_r;
      out_acc  <= acc_r;
      out_last <= (k == nm1);
    end
  end

  assign st.emit_first = emit_first;
  assign st.n_one      = (nm1 == '0);
  assign st.k_last     = (k == nm1);
  assign st.dur_zero   = (dur == '0);
  assign st.div_done   = div_done;
  assign st.out_free   = !out_valid || out_ready;

endmodule
`default_nettype wire

@@ sv/cqsi_ctrl.sv @@
// sequencer for the per-sample operations of the interpolator
`default_nettype none
module cqsi_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output cqsi_pkg::dp_cmd_t         cmd,
  input  wire cqsi_pkg::dp_status_t st
);
  import cqsi_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_op  = MUL_NONE;
    cmd.div_sel = DIV_T;
    in_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_seg = 1'b1;
          state_next   = ST_DSQ;
        end
      end
      ST_DSQ: begin
        cmd.mul_op = MUL_DD;
        state_next = ST_FIRST;
      end
      ST_FIRST: begin
        if (st.emit_first) state_next = ST_TDIV;
        else if (st.n_one) state_next = ST_DONE;
        else begin
          cmd.k_inc  = 1'b1;
          state_next = ST_TDIV;
        end
      end
      ST_TDIV: begin
        if (st.n_one) begin
          cmd.t_zero = 1'b1;
          state_next = ST_TT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_T;
          state_next    = ST_TWAIT;
        end
      end
      ST_TWAIT: if (st.div_done) state_next = ST_TT;
      ST_TT:   begin cmd.mul_op = MUL_TT; state_next = ST_P3; end
      ST_P3:   begin cmd.mul_op = MUL_P3; state_next = ST_P4; end
      ST_P4:   begin cmd.mul_op = MUL_P4; state_next = ST_P5; end
      ST_P5:   begin cmd.mul_op = MUL_P5; state_next = ST_POLY; end
      ST_POLY: begin cmd.poly = 1'b1; state_next = ST_SD; end
      ST_SD:   begin cmd.mul_op = MUL_SD; state_next = ST_POS; end
      ST_POS:  begin cmd.pos_ld = 1'b1; state_next = ST_TD; end
      ST_TD:   begin cmd.mul_op = MUL_TD; state_next = ST_TIME; end
      ST_TIME: begin cmd.time_ld = 1'b1; state_next = ST_VD; end
      ST_VD:   begin cmd.mul_op = MUL_VD; state_next = ST_VDIV; end
      ST_VDIV: begin
        if (st.dur_zero) begin
          cmd.rates_zero = 1'b1;
          state_next     = ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_V;
          state_next    = ST_VWAIT;
        end
      end
      ST_VWAIT: if (st.div_done) state_next = ST_AD;
      ST_AD:   begin cmd.mul_op = MUL_AD; state_next = ST_ADIV; end
      ST_ADIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_A;
        state_next    = ST_AWAIT;
      end
      ST_AWAIT: if (st.div_done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.k_last) state_next = ST_DONE;
          else begin
            cmd.k_inc  = 1'b1;
            state_next = ST_TDIV;
          end
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// testbench for the cubic/quintic segment interpolator: directed and random segments
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cqsi_pkg::*;

  localparam int STALL_LIMIT = 200000;
  localparam int LONG_HOLD   = 3000;

  typedef struct packed {
    logic [47:0] t;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] acc;
    logic        last;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cubic_quintic_segment_interpolator_unit dut (.*);

  // predictor state and shadow registers
  logic [47:0] time_acc;
  bit          traj_started;
  int unsigned samples_shadow;
  bit          kind_quintic;

  sample_t expected_samples[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  bit  sink_idles = 1'b1;
  bit  src_idles = 1'b1;
  int  hold_off = 0;
  int  hold_requests = 0;
  int  hold_served = 0;

  initial forever #1 clk = ~clk;

  // watchdog on cycles with no accepted request, sample or config write
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  function automatic logic signed [31:0] sat_to_32(input bit neg, input logic [63:0] m);
    if (neg) return (m > 64'h80000000) ? 32'sh80000000 : 32'(-$signed({1'b0, m}));
    return (m > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(m);
  endfunction

  function automatic logic [47:0] add_sat48(input logic [48:0] a, input logic [48:0] b);
    logic [49:0] s;
    s = a + b;
    return (s > 50'hFFFFFFFFFFFF) ? 48'hFFFFFFFFFFFF : s[47:0];
  endfunction

  // expected samples of one segment, pushed in emit order
  task automatic predict_segment(input logic signed [31:0] p0, input logic signed [31:0] p1e,
                                 input logic [31:0] dur, input bit fresh);
    int unsigned n;
    bit emit_first;
    logic [63:0] tau, w1, w2, w3, w4, w5, m, q, r, x;
    longint signed s, ds, dds, delta, prod;
    sample_t smp;
    n = samples_shadow;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    if (fresh) time_acc = '0;
    emit_first = fresh || !traj_started;
    delta = longint'(p1e) - longint'(p0);
    for (int unsigned k = 0; k < n; k++) begin
      if (k == 0 && !emit_first) continue;
      tau = (n == 1) ? 0 : (64'(k) * 131072 + (n - 1)) / (2 * (n - 1));
      w1 = tau << 8;
      w2 = (tau * tau) >> 8;
      w3 = (w2 * tau) >> 16;
      w4 = (w3 * tau) >> 16;
      w5 = (w4 * tau) >> 16;
      if (!kind_quintic) begin
        s = 3 * longint'(w2) - 2 * longint'(w3);
        ds = 6 * longint'(w1) - 6 * longint'(w2);
        dds = 6 * 64'sd16777216 - 12 * longint'(w1);
      end else begin
        s = 10 * longint'(w3) - 15 * longint'(w4) + 6 * longint'(w5);
        ds = 30 * longint'(w2) - 60 * longint'(w3) + 30 * longint'(w4);
        dds = 60 * longint'(w1) - 180 * longint'(w2) + 120 * longint'(w3);
      end
      prod = s * delta;
      m = ((prod < 0) ? -prod : prod) >> 24;
      smp.pos = sat_to_32(1'b0, 0);
      begin
        longint signed pv;
        pv = longint'(p0) + ((prod < 0) ? -longint'(m) : longint'(m));
        smp.pos = (pv > 64'sd2147483647) ? 32'h7FFFFFFF :
                  (pv < -64'sd2147483648) ? 32'h80000000 : pv[31:0];
      end
      smp.vel = '0;
      smp.acc = '0;
      if (dur != 0) begin
        prod = ds * delta;
        m = (prod < 0) ? -prod : prod;
        smp.vel = sat_to_32(prod < 0, m / ({32'b0, dur} << 8));
        prod = dds * delta;
        m = (prod < 0) ? -prod : prod;
        q = m / dur;
        r = m % dur;
        if (q >= (64'd1 << 55)) smp.acc = sat_to_32(prod < 0, 64'hFFFFFFFFFF);
        else begin
          x = (q << 8) + ((r << 8) / dur);
          smp.acc = sat_to_32(prod < 0, x / dur);
        end
      end
      smp.t = add_sat48({1'b0, time_acc}, 49'((tau * dur) >> 16));
      smp.last = (k == n - 1);
      expected_samples.push_back(smp);
    end
    time_acc = add_sat48({1'b0, time_acc}, 49'(dur));
    traj_started = 1'b1;
  endtask

  // sink side: random stalls, long hold-off on request, checks each sample
  always @(posedge clk) begin
    sample_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[47:0], m_axis_tdata[79:48], m_axis_tdata[111:80],
               m_axis_tdata[143:112], m_axis_tlast};
        if (expected_samples.size() == 0) begin
          report("unexpected sample", 64'(got.pos), 0);
        end else begin
          want = expected_samples.pop_front();
          if (got.t !== want.t) report("sample_time", 64'(got.t), 64'(want.t));
          if (got.pos !== want.pos) report("position", 64'(got.pos), 64'(want.pos));
          if (got.vel !== want.vel) report("velocity", 64'(got.vel), 64'(want.vel));
          if (got.acc !== want.acc) report("acceleration", 64'(got.acc), 64'(want.acc));
          if (got.last !== want.last) report("last_sample", 64'(got.last), 64'(want.last));
        end
      end
      if (hold_served != hold_requests) begin
        hold_served <= hold_requests;
        hold_off <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else if (sink_idles && $urandom_range(0, 7) == 0) begin
        hold_off <= $urandom_range(1, 16);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_segment(input logic [31:0] p0, input logic [31:0] p1e,
                              input logic [31:0] dur, input bit fresh);
    if (src_idles && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 16)) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {dur, p1e, p0};
    s_axis_tuser <= fresh;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_segment(p0, p1e, dur, fresh);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // block must be idle: all samples in, then a margin for a segment with no samples
  task automatic wait_drained();
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_IDX_SAMPLES) samples_shadow = val & 8'h7F;
    else if (idx == CFG_IDX_KIND) kind_quintic = val[0];
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_dur();
    case ($urandom_range(0, 5))
      0: return 32'hFFFFFFFF;
      1: return $urandom_range(1, 16);
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // extremes of positions and durations at reset settings, first segment without flag
  task automatic test_extremes();
    send_segment(32'h80000000, 32'h7FFFFFFF, 32'h00010000, 1'b0);
    send_segment(32'h7FFFFFFF, 32'h80000000, 32'h00000001, 1'b0);
    send_segment(32'h0, 32'h0, 32'hFFFFFFFF, 1'b0);
    send_segment(32'h00010000, 32'hFFFF0000, 32'h0, 1'b1);
    send_segment(32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 1'b0);
    wait_drained();
  endtask

  // cubic and quintic at small and large sample counts, zero and over-range count
  task automatic test_settings();
    write_reg(CFG_IDX_KIND, 8'd0);
    write_reg(CFG_IDX_SAMPLES, 8'd2);
    send_segment(32'h00000000, 32'h00100000, 32'h00020000, 1'b1);
    send_segment(32'h00100000, 32'h80000000, 32'h00000003, 1'b0);
    wait_drained();
    write_reg(CFG_IDX_SAMPLES, 8'd0);
    send_segment(32'h00050000, 32'h7FFFFFFF, 32'h00010000, 1'b1);
    send_segment(32'h00050000, 32'h00060000, 32'h00010000, 1'b0);
    send_segment(32'h00060000, 32'h00070000, 32'h0, 1'b0);
    wait_drained();
    write_reg(CFG_IDX_SAMPLES, 8'd127);
    send_segment(32'h80000000, 32'h7FFFFFFF, 32'h00000002, 1'b0);
    wait_drained();
    write_reg(CFG_IDX_KIND, 8'd1);
    write_reg(CFG_IDX_SAMPLES, 8'd3);
    send_segment(32'h7FFFFFFF, 32'h80000000, 32'h00008000, 1'b1);
    send_segment(32'h80000000, 32'h00000000, 32'hFFFFFFFF, 1'b0);
    wait_drained();
    write_reg(8'd200, 8'd5);
    write_reg(CFG_IDX_SAMPLES, 8'd1);
    send_segment(32'h00010000, 32'h00020000, 32'h00010000, 1'b0);
    wait_drained();
  endtask

  // sink held off while the source keeps offering segments
  task automatic test_backpressure();
    write_reg(CFG_IDX_SAMPLES, 8'd4);
    hold_requests++;
    repeat (5) send_segment(rand_pos(), rand_pos(), rand_dur(), 1'b0);
    wait_drained();
  endtask

  // random trajectories, mostly short sample counts, a few long ones
  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_IDX_KIND, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(CFG_IDX_SAMPLES, (phase == 3) ? 8'd64 : CFG_DATA_W'($urandom_range(0, 9)));
      if (phase == 6) begin
        sink_idles = 1'b0;
        src_idles = 1'b0;
      end
      for (int i = 0; i < ((phase == 3) ? 6 : 22); i++)
        send_segment(rand_pos(), rand_pos(), rand_dur(), $urandom_range(0, 5) == 0);
      wait_drained();
    end
  endtask

  initial begin
    time_acc = '0;
    traj_started = 1'b0;
    samples_shadow = 64;
    kind_quintic = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_settings();
    test_backpressure();
    test_random();
    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
sv/cqsi_pkg.sv
sv/cqsi_div.sv
sv/cqsi_datapath.sv
sv/cqsi_ctrl.sv
sv/cubic_quintic_segment_interpolator_unit.sv
verif/testbench.sv
